[hw/rtl/sbfh_pkg.sv]
// Shared types and constants for the segment/box first-hit block.
// No dependencies; every other file in hw/rtl imports this package.
package sbfh_pkg;

    localparam int COORD_W   = 16;
    localparam int HALF_W    = 12;
    localparam int NUM_W     = 18;
    localparam int DEN_W     = 17;
    localparam int PROD_W    = 2 * NUM_W;
    localparam int ROT_W     = 9;
    localparam int INDEX_W   = 8;
    localparam int DEF_MAX_PIECES = 256;

    localparam logic [HALF_W-1:0] HALF_THICK_RESET = 12'd160;
    localparam logic [HALF_W-1:0] HALF_LEN_RESET   = 12'd800;

    localparam logic [ROT_W-1:0] ROT_VERT_A = 9'd90;
    localparam logic [ROT_W-1:0] ROT_VERT_B = 9'd270;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_THICK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_LEN   = 1'd1;

    typedef enum logic [1:0] {
        AX_EMPTY = 2'd0,
        AX_ALL   = 2'd1,
        AX_SPAN  = 2'd2
    } axis_kind_t;

    typedef struct packed {
        axis_kind_t              kind;
        logic signed [NUM_W-1:0] n_lo;
        logic signed [NUM_W-1:0] n_hi;
        logic [DEN_W-1:0]        d_abs;
    } span_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SPAN = 2'd1,
        ST_MUL  = 2'd2,
        ST_FIN  = 2'd3
    } state_t;

endpackage

[hw/rtl/sbfh_span.sv]
// Per-axis slab span: entry and exit numerators over the absolute direction.
// Depends on sbfh_pkg.
module sbfh_span (
    input  logic                                 aclk,
    input  logic                                 load,
    input  logic signed [sbfh_pkg::COORD_W-1:0]  org,
    input  logic signed [sbfh_pkg::COORD_W-1:0]  tgt,
    input  logic signed [sbfh_pkg::COORD_W-1:0]  ctr,
    input  logic        [sbfh_pkg::HALF_W-1:0]   half,
    output sbfh_pkg::span_t                      span
);
    import sbfh_pkg::*;

    logic signed [NUM_W-1:0] o_ext, dir, bmin, bmax, n1, n2;
    span_t span_reg, span_next;

    always_comb begin
        o_ext = NUM_W'(org);
        dir   = NUM_W'(tgt) - o_ext;
        bmin  = NUM_W'(ctr) - NUM_W'(signed'({1'b0, half}));
        bmax  = NUM_W'(ctr) + NUM_W'(signed'({1'b0, half}));
        n1    = bmin - o_ext;
        n2    = bmax - o_ext;
        span_next = span_reg;
        if (dir == '0) begin
            span_next.kind = (bmin <= o_ext && o_ext <= bmax) ? AX_ALL : AX_EMPTY;
            span_next.n_lo = '0;
            span_next.n_hi = '0;
            span_next.d_abs = '0;
        end else if (!dir[NUM_W-1]) begin
            span_next.kind  = AX_SPAN;
            span_next.n_lo  = n1;
            span_next.n_hi  = n2;
            span_next.d_abs = dir[DEN_W-1:0];
        end else begin
            span_next.kind  = AX_SPAN;
            span_next.n_lo  = -n2;
            span_next.n_hi  = -n1;
            span_next.d_abs = DEN_W'(-dir);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            span_reg <= span_next;
        end
    end

    assign span = span_reg;

endmodule

[hw/rtl/sbfh_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on sbfh_pkg.
module sbfh_mul (
    input  logic                                aclk,
    input  logic signed [sbfh_pkg::NUM_W-1:0]   op_a,
    input  logic signed [sbfh_pkg::NUM_W-1:0]   op_b,
    output logic signed [sbfh_pkg::PROD_W-1:0]  prod
);
    import sbfh_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/segment_box_first_hit.sv]
// Top level of the segment/box first-hit block: sequencer, list state and ports.
// Depends on sbfh_pkg, sbfh_span and sbfh_mul.
//
// Each input beat carries one wall piece of a shot's list together with the
// shot's origin and target. A wall piece is tested between acceptance and
// ready in order: both axis spans are formed, then eight steps run on the
// single shared 18x18 multiplier (four cross products to pick the entry
// and exit fractions, two to compare them, with the product register in
// between), and a finish step folds the outcome into the list state. Floors,
// pieces after a hit and pieces past MAX_PIECES go straight to the finish
// step. The block holds one piece at a time and is not ready while it works.
// On the beat marked tlast one result beat is issued; it sits in an output
// register, and the block stalls only if a second result is due while the first waits.
module segment_box_first_hit #(
    parameter int MAX_PIECES = sbfh_pkg::DEF_MAX_PIECES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sbfh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sbfh_pkg::HALF_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // origin_x, origin_y, target_x, target_y, piece_x, piece_y, rotation_deg, zero pad
    input  logic [111:0]                        s_tdata,
    // is_floor
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit, hit_index, too_many, zero pad
    output logic [15:0]                         m_tdata
);
    import sbfh_pkg::*;

    localparam int CNT_W = $clog2(MAX_PIECES + 2);

    // Configuration registers.
    logic [HALF_W-1:0] half_thick_reg, half_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_thick_reg <= HALF_THICK_RESET;
            half_len_reg   <= HALF_LEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HALF_THICK: half_thick_reg <= cfg_wdata;
                REG_HALF_LEN:   half_len_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;

    // Captured piece.
    logic signed [COORD_W-1:0] ox_reg, oy_reg, tx_reg, ty_reg, px_reg, py_reg;
    logic vert_reg, last_reg, test_reg;
    logic [CNT_W-1:0] pos_reg;

    // List state.
    logic hit_found_reg;
    logic [INDEX_W-1:0] first_idx_reg;
    logic [CNT_W-1:0] seen_reg;

    // Sequencer working registers.
    logic signed [PROD_W-1:0] hold_reg;
    logic enter_y_reg, leave_x_reg, piece_hit_reg;

    logic [15:0] m_tdata_reg;
    logic m_tvalid_reg;

    span_t span_x, span_y;
    logic signed [PROD_W-1:0] prod;
    logic signed [NUM_W-1:0] op_a, op_b;
    logic accept, span_load, lt;
    logic [HALF_W-1:0] hx, hy;
    logic signed [NUM_W-1:0] enter_n, leave_n, enter_d, leave_d, dx_s, dy_s;
    logic geom_ok, fin_go;
    logic [CNT_W+INDEX_W-1:0] pos_ext;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign span_load = (state_reg == ST_SPAN);

    assign hx = vert_reg ? half_thick_reg : half_len_reg;
    assign hy = vert_reg ? half_len_reg : half_thick_reg;

    sbfh_span u_span_x (
        .aclk (aclk), .load (span_load),
        .org (ox_reg), .tgt (tx_reg), .ctr (px_reg), .half (hx),
        .span (span_x)
    );

    sbfh_span u_span_y (
        .aclk (aclk), .load (span_load),
        .org (oy_reg), .tgt (ty_reg), .ctr (py_reg), .half (hy),
        .span (span_y)
    );

    sbfh_mul u_mul (
        .aclk (aclk), .op_a (op_a), .op_b (op_b), .prod (prod)
    );

    assign dx_s    = signed'({1'b0, span_x.d_abs});
    assign dy_s    = signed'({1'b0, span_y.d_abs});
    assign enter_n = enter_y_reg ? span_y.n_lo : span_x.n_lo;
    assign enter_d = enter_y_reg ? dy_s : dx_s;
    assign leave_n = leave_x_reg ? span_x.n_hi : span_y.n_hi;
    assign leave_d = leave_x_reg ? dx_s : dy_s;

    // Fraction a < b is a.n * b.d < b.n * a.d; hold keeps the left-hand product.
    assign lt = hold_reg < prod;

    // Either slab missed, or the segment is a point inside both slabs: no hit.
    assign geom_ok = (span_x.kind != AX_EMPTY) && (span_y.kind != AX_EMPTY)
                     && !(span_x.kind == AX_ALL && span_y.kind == AX_ALL);

    always_comb begin
        case (step_reg)
            3'd0: begin op_a = span_x.n_lo; op_b = dy_s; end
            3'd1: begin op_a = span_y.n_lo; op_b = dx_s; end
            3'd2: begin op_a = span_x.n_hi; op_b = dy_s; end
            3'd3: begin op_a = span_y.n_hi; op_b = dx_s; end
            3'd5: begin op_a = leave_n;     op_b = enter_d; end
            3'd6: begin op_a = enter_n;     op_b = leave_d; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // The finish cycle waits only while an earlier result is still unread.
    assign fin_go = !(last_reg && m_tvalid_reg && !m_tready);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SPAN;
                    if (s_tuser || hit_found_reg || seen_reg >= CNT_W'(MAX_PIECES)) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SPAN: begin
                state_next = ST_MUL;
                step_next  = 3'd0;
            end
            ST_MUL: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ox_reg   <= s_tdata[15:0];
            oy_reg   <= s_tdata[31:16];
            tx_reg   <= s_tdata[47:32];
            ty_reg   <= s_tdata[63:48];
            px_reg   <= s_tdata[79:64];
            py_reg   <= s_tdata[95:80];
            vert_reg <= (s_tdata[104:96] == ROT_VERT_A) || (s_tdata[104:96] == ROT_VERT_B);
            last_reg <= s_tlast;
            pos_reg  <= seen_reg;
        end
        if (state_reg == ST_MUL) begin
            case (step_reg)
                3'd1, 3'd3, 3'd6: hold_reg <= prod;
                3'd2: begin
                    if (span_x.kind == AX_ALL) begin
                        enter_y_reg <= 1'b1;
                    end else if (span_y.kind == AX_ALL) begin
                        enter_y_reg <= 1'b0;
                    end else begin
                        enter_y_reg <= lt;
                    end
                end
                3'd4: begin
                    if (span_x.kind == AX_ALL) begin
                        leave_x_reg <= 1'b0;
                    end else if (span_y.kind == AX_ALL) begin
                        leave_x_reg <= 1'b1;
                    end else begin
                        leave_x_reg <= lt;
                    end
                end
                default: ;
            endcase
        end
    end

    // test_reg marks a piece that went through the multiplier sequence.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            test_reg      <= 1'b0;
            piece_hit_reg <= 1'b0;
        end else if (accept) begin
            test_reg      <= 1'b0;
            piece_hit_reg <= 1'b0;
        end else if (state_reg == ST_MUL && step_reg == 3'd7) begin
            test_reg      <= 1'b1;
            piece_hit_reg <= geom_ok && !lt && !enter_n[NUM_W-1] && (enter_n <= enter_d);
        end
    end

    assign pos_ext = {{INDEX_W{1'b0}}, pos_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg <= 1'b0;
            first_idx_reg <= '0;
            seen_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end else begin
            // A new result may replace one that is being read in the same cycle.
            if (state_reg == ST_FIN && fin_go && last_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (accept && seen_reg <= CNT_W'(MAX_PIECES)) begin
                seen_reg <= seen_reg + 1'b1;
            end
            if (state_reg == ST_FIN && fin_go) begin
                if (last_reg) begin
                    if (test_reg && piece_hit_reg) begin
                        m_tdata_reg <= {6'd0, (seen_reg > CNT_W'(MAX_PIECES)),
                                        pos_ext[INDEX_W-1:0], 1'b1};
                    end else begin
                        m_tdata_reg <= {6'd0, (seen_reg > CNT_W'(MAX_PIECES)),
                                        (hit_found_reg ? first_idx_reg : 8'd0),
                                        hit_found_reg};
                    end
                    hit_found_reg <= 1'b0;
                    first_idx_reg <= '0;
                    seen_reg      <= '0;
                end else if (test_reg && piece_hit_reg) begin
                    hit_found_reg <= 1'b1;
                    first_idx_reg <= pos_ext[INDEX_W-1:0];
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_seen_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= CNT_W'(MAX_PIECES + 1))
        else $error("piece counter passed its saturation value");

    a_idx_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !hit_found_reg |-> first_idx_reg == '0)
        else $error("first hit index set without a hit");

    a_result_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
        else $error("result carries an index but no hit");

    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_FIN && last_reg))
        else $error("result issued outside the end of a list");

endmodule

[bench/tb_top.sv]
// Self-checking bench for segment_box_first_hit: random and directed shot lists
// with a scoreboard that predicts the first-hit result. Depends on sbfh_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sbfh_pkg::*;

    // One wall piece as it travels on the input stream.
    typedef struct {
        logic signed [15:0] ox, oy, tx, ty, px, py;
        logic [8:0]         rot;
        logic               is_floor;
        logic               last;
    } piece_t;

    typedef struct {
        logic       hit;
        logic [7:0] idx;
        logic       too_many;
    } shot_res_t;

    // Scoreboard: keeps its own copy of the list state and the half sizes,
    // and queues the result expected at the end of each list.
    class hit_board;
        logic [11:0] half_thick, half_len;
        logic        found;
        logic [7:0]  first_idx;
        int          seen;
        shot_res_t   pending[$];
        int          errors;
        int          shown;

        function new();
            half_thick = HALF_THICK_RESET;
            half_len   = HALF_LEN_RESET;
            found = 0; first_idx = 0; seen = 0; errors = 0; shown = 0;
        endfunction

        // Fraction a < b, both denominators positive.
        function bit frac_less(longint an, longint ad, longint bn, longint bd);
            return an * bd < bn * ad;
        endfunction

        // Classifies one axis and gives the entry and exit fractions over a
        // shared positive denominator.
        function axis_kind_t axis_range(longint o, longint d, longint c, longint h,
                                        output longint lo_n, output longint hi_n,
                                        output longint den);
            longint bmin, bmax;
            bmin = c - h;
            bmax = c + h;
            lo_n = 0; hi_n = 0; den = 1;
            if (d == 0)
                return (bmin <= o && o <= bmax) ? AX_ALL : AX_EMPTY;
            if (d > 0) begin
                lo_n = bmin - o; hi_n = bmax - o; den = d;
            end else begin
                lo_n = o - bmax; hi_n = o - bmin; den = -d;
            end
            return AX_SPAN;
        endfunction

        function bit segment_enters(piece_t p);
            longint hx, hy, lxn, uxn, dxd, lyn, uyn, dyd;
            longint en, ed, ln, ld;
            axis_kind_t kx, ky;
            bit vert;
            vert = (p.rot == ROT_VERT_A || p.rot == ROT_VERT_B);
            hx = longint'(vert ? half_thick : half_len);
            hy = longint'(vert ? half_len : half_thick);
            kx = axis_range(longint'(p.ox), longint'(p.tx) - longint'(p.ox),
                            longint'(p.px), hx, lxn, uxn, dxd);
            ky = axis_range(longint'(p.oy), longint'(p.ty) - longint'(p.oy),
                            longint'(p.py), hy, lyn, uyn, dyd);
            if (kx == AX_EMPTY || ky == AX_EMPTY) return 0;
            if (kx == AX_ALL && ky == AX_ALL) return 0;
            if (kx == AX_ALL) begin
                en = lyn; ed = dyd; ln = uyn; ld = dyd;
            end else if (ky == AX_ALL) begin
                en = lxn; ed = dxd; ln = uxn; ld = dxd;
            end else begin
                if (frac_less(lxn, dxd, lyn, dyd)) begin en = lyn; ed = dyd; end
                else begin en = lxn; ed = dxd; end
                if (frac_less(uxn, dxd, uyn, dyd)) begin ln = uxn; ld = dxd; end
                else begin ln = uyn; ld = dyd; end
            end
            if (frac_less(ln, ld, en, ed)) return 0;
            return en >= 0 && en <= ed;
        endfunction

        function void note_piece(piece_t p);
            int pos;
            shot_res_t r;
            pos = seen;
            if (seen <= DEF_MAX_PIECES) seen++;
            if (pos < DEF_MAX_PIECES && !p.is_floor && !found && segment_enters(p)) begin
                found = 1;
                first_idx = pos[7:0];
            end
            if (p.last) begin
                r.hit = found;
                r.idx = found ? first_idx : 8'd0;
                r.too_many = seen > DEF_MAX_PIECES;
                pending.push_back(r);
                found = 0; first_idx = 0; seen = 0;
            end
        endfunction

        function void check_result(logic [15:0] data);
            shot_res_t e;
            if (pending.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result beat %h", data);
                end
                return;
            end
            e = pending.pop_front();
            if (data[0] !== e.hit || data[8:1] !== e.idx || data[9] !== e.too_many
                || data[15:10] !== 6'd0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("result mismatch: expected hit %0d idx %0d many %0d, got %h",
                             e.hit, e.idx, e.too_many, data);
                end
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [0:0]  cfg_index = REG_HALF_THICK;
    logic [11:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [111:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;

    hit_board board = new();

    // Idling rates in percent; changed between phases.
    int send_idle = 36;
    int recv_idle = 48;
    bit hold_off = 0;      // long receiver stall requested
    int sent = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    segment_box_first_hit dut (.*);

    // Receiver: random stalls, plus a long hold-off stretch on request.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // Offers one piece and waits until the beat is taken. The scoreboard is
    // told at the accepting edge itself. tvalid stays high into the next
    // piece unless the sender idles first; drain() drops it at the end.
    task automatic send_piece(piece_t p);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {p.rot, p.py, p.px, p.ty, p.tx, p.oy, p.ox};
        s_tuser  <= p.is_floor;
        s_tlast  <= p.last;
        do @(posedge aclk); while (!s_tready);
        board.note_piece(p);
        sent++;
    endtask

    // Waits for every expected result, then for the block's own latency.
    task automatic drain();
        int n;
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        for (n = 0; n < 30; n++) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [11:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == REG_HALF_THICK) board.half_thick = val;
        else board.half_len = val;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // A random piece near a random shot: most shots are short so hits occur.
    function automatic piece_t rand_piece(logic signed [15:0] ox, logic signed [15:0] oy,
                                          logic signed [15:0] tx, logic signed [15:0] ty,
                                          bit last);
        piece_t p;
        int r;
        p.ox = ox; p.oy = oy; p.tx = tx; p.ty = ty;
        r = $urandom_range(9);
        if (r < 7) begin
            p.px = ox + $signed(16'($urandom_range(4000))) - 16'sd1000;
            p.py = oy + $signed(16'($urandom_range(4000))) - 16'sd1000;
        end else begin
            p.px = rnd16(); p.py = rnd16();
        end
        r = $urandom_range(5);
        p.rot = r == 0 ? 9'd90 : r == 1 ? 9'd270 : r == 2 ? 9'd0 : 9'($urandom);
        p.is_floor = $urandom_range(5) == 0;
        p.last = last;
        return p;
    endfunction

    task automatic random_shot(int len);
        logic signed [15:0] ox, oy, tx, ty;
        int k;
        if ($urandom_range(9) == 0) begin
            ox = rnd16(); oy = rnd16(); tx = rnd16(); ty = rnd16();
        end else begin
            ox = $signed(16'($urandom_range(8000))) - 16'sd4000;
            oy = $signed(16'($urandom_range(8000))) - 16'sd4000;
            tx = $urandom_range(4) == 0 ? ox : ox + $signed(16'($urandom_range(6000))) - 16'sd3000;
            ty = $urandom_range(4) == 0 ? oy : oy + $signed(16'($urandom_range(6000))) - 16'sd3000;
        end
        for (k = 0; k < len; k++) begin
            // Now and then a shot's coordinates change within a list.
            if ($urandom_range(19) == 0) begin tx = rnd16(); ty = rnd16(); end
            send_piece(rand_piece(ox, oy, tx, ty, k == len - 1));
        end
    endtask

    function automatic piece_t mk(int ox, int oy, int tx, int ty, int px, int py,
                                  int rot, bit fl, bit last);
        piece_t p;
        p.ox = 16'(ox); p.oy = 16'(oy); p.tx = 16'(tx); p.ty = 16'(ty);
        p.px = 16'(px); p.py = 16'(py);
        p.rot = 9'(rot); p.is_floor = fl; p.last = last;
        return p;
    endfunction

    initial begin
        int k;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part with the reset half sizes.
        send_piece(mk(0, 0, 2000, 0, 1000, 0, 0, 0, 1));          // plain hit
        send_piece(mk(0, 0, 2000, 0, 1000, 0, 0, 1, 1));          // floor as last item
        send_piece(mk(0, 0, 0, 2000, 0, 1000, 90, 0, 1));         // vertical, dx zero inside
        send_piece(mk(2000, 0, 2000, 3000, 0, 1000, 270, 0, 1));  // dx zero outside slab
        send_piece(mk(5, 5, 5, 5, 900, 0, 0, 0, 1));              // zero direction
        send_piece(mk(1000, 0, 3000, 0, 1000, 0, 0, 0, 1));       // origin inside box
        send_piece(mk(-32768, -32768, 32767, 32767, 0, 0, 511, 0, 0));
        send_piece(mk(32767, 32767, -32768, -32768, -32768, 32767, 360, 0, 0));
        send_piece(mk(0, 0, 800, 0, 1600, 0, 0, 0, 1));           // touches edge at t = 1
        send_piece(mk(0, 0, 100, 0, 5000, 0, 90, 0, 0));
        send_piece(mk(0, 0, 100, 0, 100, 0, 0, 0, 0));
        send_piece(mk(0, 0, 100, 0, 100, 0, 0, 0, 1));            // origin inside box, so no hit in the list
        drain();

        // Extreme half sizes.
        write_reg(REG_HALF_THICK, 12'd0);
        write_reg(REG_HALF_LEN, 12'd4095);
        send_piece(mk(0, -100, 0, 100, 0, 0, 0, 0, 1));
        send_piece(mk(0, -100, 0, 100, 0, 0, 90, 0, 1));
        drain();
        write_reg(REG_HALF_THICK, 12'd4095);
        write_reg(REG_HALF_LEN, 12'd0);
        send_piece(mk(-32768, 0, 32767, 0, 0, 0, 270, 0, 1));
        drain();

        // Overflowing list: more than MAX_PIECES items, hit past index 255.
        write_reg(REG_HALF_THICK, 12'd160);
        write_reg(REG_HALF_LEN, 12'd800);
        send_idle = 0;
        for (k = 0; k < 262; k++)
            send_piece(mk(0, 0, 2000, 0, k >= 258 ? 1000 : 20000, 0, 0, 0, k == 261));
        for (k = 0; k < 300; k++)
            send_piece(mk(0, 0, 2000, 0, k == 256 ? 1000 : 20000, 0, 0, 0, k == 299));
        drain();

        // Random phases.
        send_idle = 36; recv_idle = 48;
        while (sent < 650) random_shot($urandom_range(1, 8));
        drain();
        write_reg(REG_HALF_THICK, 12'($urandom));
        write_reg(REG_HALF_LEN, 12'($urandom));
        send_idle = 48; recv_idle = 36;
        while (sent < 750) random_shot($urandom_range(1, 8));
        drain();
        write_reg(REG_HALF_THICK, 12'($urandom_range(400)));
        write_reg(REG_HALF_LEN, 12'($urandom_range(2000)));
        send_idle = 0; recv_idle = 0;
        // Long receiver hold-off while short lists keep the input busy.
        fork
            begin
                hold_off = 1;
                for (k = 0; k < 400; k++) @(posedge aclk);
                hold_off = 0;
            end
            while (sent < 850) random_shot($urandom_range(1, 3));
        join
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
